/* rtl/core/tpkt_pkg.sv */
// tpkt_pkg: shared types and constants for the TPKT stream deframer.
// No dependencies; used by tpkt_stream_deframer and its checker.

package tpkt_pkg;

    localparam int PLEN_W = 24;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_HEADER  = 3'd0;
    localparam kind_t KIND_PAYLOAD = 3'd1;
    localparam kind_t KIND_EMPTY   = 3'd2;
    localparam kind_t KIND_BADVER  = 3'd3;
    localparam kind_t KIND_BADLEN  = 3'd4;

    localparam logic [7:0] TPKT_VERSION = 8'd3;
    localparam int         HEADER_BYTES = 4;

endpackage

/* rtl/core/tpkt_stream_deframer.sv */
// tpkt_stream_deframer: TPKT (RFC 1006 style) packet deframer, one byte per item.
// Depends on tpkt_pkg.

// Takes one stream byte per item and returns exactly one result item for each,
// in the cycle after acceptance. A new byte can be accepted every cycle: the
// result sits in an output register, and in_ready is high whenever that register
// is empty or being drained. Per-byte work is a header shift/compare or a
// payload-counter decrement. A header starts with version byte 3 followed by a
// big-endian length (low LENGTH_BITS bits kept) that includes the 4 header
// bytes; bad version bytes, lengths below 4 and empty packets are reported and
// the block returns to idle.

module tpkt_stream_deframer #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               data_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tpkt_pkg::kind_t          kind,
    output logic [7:0]               payload_byte,
    output logic                     last_of_packet,
    output logic [tpkt_pkg::PLEN_W-1:0] payload_length
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [1:0] HDR_LAST_CNT = 2'(tpkt_pkg::HEADER_BYTES - 1);
    localparam logic [LENGTH_BITS-1:0] HDR_LEN = LENGTH_BITS'(tpkt_pkg::HEADER_BYTES);
    localparam logic [LENGTH_BITS-1:0] ONE_L   = LENGTH_BITS'(1);

    logic [1:0]             phase_reg, phase_next;
    logic [1:0]             hdr_cnt_reg, hdr_cnt_next;
    logic [LENGTH_BITS-1:0] accum_reg, accum_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [LENGTH_BITS-1:0] plen_reg, plen_next;

    logic                   out_valid_reg;
    tpkt_pkg::kind_t        kind_reg, kind_next;
    logic [7:0]             pbyte_reg, pbyte_next;
    logic                   last_reg, last_next;
    logic [LENGTH_BITS-1:0] olen_reg, olen_next;

    logic                   accept;
    logic [LENGTH_BITS-1:0] total;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign total    = {accum_reg[LENGTH_BITS-9:0], data_byte};

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        accum_next   = accum_reg;
        left_next    = left_reg;
        plen_next    = plen_reg;
        kind_next    = tpkt_pkg::KIND_HEADER;
        pbyte_next   = 8'd0;
        last_next    = 1'b0;
        olen_next    = '0;
        case (phase_reg)
            PH_BODY:
            begin
                kind_next  = tpkt_pkg::KIND_PAYLOAD;
                pbyte_next = data_byte;
                olen_next  = plen_reg;
                left_next  = left_reg - ONE_L;
                if (left_reg == ONE_L)
                begin
                    last_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_HEADER:
            begin
                accum_next   = total;
                hdr_cnt_next = hdr_cnt_reg + 2'd1;
                if (hdr_cnt_reg == HDR_LAST_CNT)
                begin
                    if (total < HDR_LEN)
                    begin
                        kind_next  = tpkt_pkg::KIND_BADLEN;
                        phase_next = PH_IDLE;
                    end
                    else if (total == HDR_LEN)
                    begin
                        kind_next  = tpkt_pkg::KIND_EMPTY;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        left_next  = total - HDR_LEN;
                        plen_next  = total - HDR_LEN;
                        olen_next  = total - HDR_LEN;
                        phase_next = PH_BODY;
                    end
                end
            end
            default:
            begin
                if (data_byte != tpkt_pkg::TPKT_VERSION)
                begin
                    kind_next  = tpkt_pkg::KIND_BADVER;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next   = PH_HEADER;
                    hdr_cnt_next = 2'd1;
                    accum_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_cnt_reg   <= 2'd0;
            accum_reg     <= '0;
            left_reg      <= '0;
            plen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                hdr_cnt_reg <= hdr_cnt_next;
                accum_reg   <= accum_next;
                left_reg    <= left_next;
                plen_reg    <= plen_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_next;
            pbyte_reg <= pbyte_next;
            last_reg  <= last_next;
            olen_reg  <= olen_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = pbyte_reg;
    assign last_of_packet = last_reg;
    assign payload_length = tpkt_pkg::PLEN_W'(olen_reg);

endmodule

/* rtl/core/tpkt_deframer_checker.sv */
// tpkt_deframer_checker: port-level assertions for tpkt_stream_deframer.
// Depends on tpkt_pkg; bound to tpkt_stream_deframer below.

module tpkt_deframer_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input tpkt_pkg::kind_t               kind,
    input logic [7:0]                    payload_byte,
    input logic                          last_of_packet,
    input logic [tpkt_pkg::PLEN_W-1:0]   payload_length
);

    // every accepted byte shows a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(payload_byte) && $stable(payload_length))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= tpkt_pkg::KIND_BADLEN)
        else $error("kind out of range");

    a_non_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != tpkt_pkg::KIND_PAYLOAD |-> payload_byte == 8'd0
            && !last_of_packet)
        else $error("payload fields set on non-payload item");

    a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == tpkt_pkg::KIND_BADVER || kind == tpkt_pkg::KIND_BADLEN
            || kind == tpkt_pkg::KIND_EMPTY) |-> payload_length == '0)
        else $error("length reported on error or empty packet");

endmodule

bind tpkt_stream_deframer tpkt_deframer_checker u_tpkt_deframer_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .last_of_packet (last_of_packet),
    .payload_length (payload_length)
);
